[sv/vig_pkg.sv]
// ----------------------------------------------------------------------------
// vig_pkg
// Shared sizes, field widths and codes of the alphabet Vigenere cipher.
// ----------------------------------------------------------------------------
package vig_pkg;

  localparam int ALPHA_DEPTH = 64;
  localparam int KEY_DEPTH   = 64;
  localparam int ALPHA_AW    = $clog2(ALPHA_DEPTH);
  localparam int KEY_AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int ALEN_W      = $clog2(ALPHA_DEPTH + 1);
  localparam int KLEN_W      = $clog2(KEY_DEPTH + 1);

  localparam int SYM_W       = 21;
  localparam int SLOT_W      = 6;
  localparam int FUNC_W      = 2;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 24;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_ALPHA = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_KEY   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEXT       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT   = 2'd2;

endpackage

[sv/vig_ram.sv]
// ----------------------------------------------------------------------------
// vig_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/alphabet_vigenere_cipher.sv]
// ----------------------------------------------------------------------------
// alphabet_vigenere_cipher
// Vigenere cipher over a loadable alphabet of code points, searched with one
// shared comparator.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  s_*      in         tuser: func; tdata: symbol, slot, first
//  m_*      out        tuser: in_alphabet; tdata: out_symbol
//  cfg_*    in         register index and value, one write per enabled cycle
//
//  A load beat is written into its table as it is accepted. A text beat
//  keeps s_tready low through one key RAM read, two comparator passes over
//  the alphabet RAM (key symbol, then text symbol), each ending at a match
//  or when the scan runs out, one result read (only on a text match) and one
//  output load, which can stall. Each pass stops at its first match.
//  Reset clears control state only; table contents are undefined until loaded.
//  A result waits in the output register while the next beat is taken; the
//  output load stalls while an earlier result still waits there.
// ----------------------------------------------------------------------------
module alphabet_vigenere_cipher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // func
  input  logic [vig_pkg::FUNC_W-1:0]       s_tuser,
  // symbol [20:0], slot [26:21], first [27], zero [31:28]
  input  logic [vig_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // in_alphabet
  output logic                             m_tuser,
  // out_symbol [20:0], zero [23:21]
  output logic [vig_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_we,
  input  logic [vig_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vig_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AAW = vig_pkg::ALPHA_AW;
  localparam int KAW = vig_pkg::KEY_AW;
  localparam int ALW = vig_pkg::ALEN_W;
  localparam int KLW = vig_pkg::KLEN_W;
  localparam int SW  = vig_pkg::SYM_W;
  localparam int IW  = vig_pkg::ALEN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEY_RD, ST_SCAN_KEY, ST_SCAN_TXT, ST_OUT_RD, ST_OUT_WR
  } state_t;

  state_t                      state;
  logic [vig_pkg::CFG_W-1:0]   alphabet_length;
  logic [vig_pkg::CFG_W-1:0]   key_length;
  logic                        decrypt_mode;
  logic [KAW-1:0]              key_position;
  logic [KAW-1:0]              kp_cur;
  logic [SW-1:0]               sym;
  logic [ALW-1:0]              scan_cnt;
  logic                        rd_vld;
  logic [AAW-1:0]              rd_idx;
  logic [AAW-1:0]              shift;
  logic [AAW-1:0]              out_idx;
  logic                        found;

  logic [vig_pkg::FUNC_W-1:0]  in_func;
  logic [SW-1:0]               in_symbol;
  logic [vig_pkg::SLOT_W-1:0]  in_slot;
  logic                        in_first;
  logic                        accept;
  logic [ALW-1:0]              alen;
  logic [KLW-1:0]              klen;
  logic [KAW-1:0]              kp_start;
  logic [KAW-1:0]              kp_after;
  logic                        alpha_we;
  logic                        key_we;
  logic [AAW-1:0]              alpha_raddr;
  logic [SW-1:0]               alpha_rdata;
  logic [SW-1:0]               key_rdata;
  logic [SW-1:0]               target;
  logic                        hit;
  logic                        miss;
  logic [AAW-1:0]              issue_addr;
  logic                        issue;
  logic [IW-1:0]               idx_sum;
  logic [AAW-1:0]              idx_next;
  logic                        out_free;

  assign in_func   = s_tuser;
  assign in_symbol = s_tdata[SW-1:0];
  assign in_slot   = s_tdata[SW+vig_pkg::SLOT_W-1:SW];
  assign in_first  = s_tdata[SW+vig_pkg::SLOT_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (32'(alphabet_length) > vig_pkg::ALPHA_DEPTH) begin
      alen = ALW'(vig_pkg::ALPHA_DEPTH);
    end else begin
      alen = ALW'(alphabet_length);
    end
    if (key_length == '0) begin
      klen = KLW'(1);
    end else if (32'(key_length) > vig_pkg::KEY_DEPTH) begin
      klen = KLW'(vig_pkg::KEY_DEPTH);
    end else begin
      klen = KLW'(key_length);
    end
  end

  always_comb begin
    kp_start = in_first ? '0 : key_position;
    if (32'(kp_start) >= 32'(klen)) begin
      kp_start = '0;
    end
    if (32'(kp_start) + 1 >= 32'(klen)) begin
      kp_after = '0;
    end else begin
      kp_after = KAW'(32'(kp_start) + 1);
    end
  end

  assign alpha_we = accept && (in_func == vig_pkg::FUNC_LOAD_ALPHA)
                    && (32'(in_slot) < vig_pkg::ALPHA_DEPTH);
  assign key_we   = accept && (in_func == vig_pkg::FUNC_LOAD_KEY)
                    && (32'(in_slot) < vig_pkg::KEY_DEPTH);

  assign issue      = (scan_cnt < alen);
  assign issue_addr = AAW'(scan_cnt);

  always_comb begin
    unique case (state)
      ST_SCAN_KEY, ST_SCAN_TXT: alpha_raddr = issue_addr;
      ST_OUT_RD, ST_OUT_WR:     alpha_raddr = out_idx;
      default:                  alpha_raddr = '0;
    endcase
  end

  assign target = (state == ST_SCAN_KEY) ? key_rdata : sym;
  assign hit    = rd_vld && (alpha_rdata == target);
  assign miss   = !rd_vld && !issue;

  always_comb begin
    if (decrypt_mode) begin
      idx_sum = IW'(rd_idx) + IW'(alen) - IW'(shift);
    end else begin
      idx_sum = IW'(rd_idx) + IW'(shift);
    end
    if (idx_sum >= IW'(alen)) begin
      idx_sum = idx_sum - IW'(alen);
    end
    idx_next = AAW'(idx_sum);
  end

  vig_ram #(
    .WIDTH (SW),
    .DEPTH (vig_pkg::ALPHA_DEPTH),
    .AW    (AAW)
  ) u_alpha_ram (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (AAW'(in_slot)),
    .wdata (in_symbol),
    .raddr (alpha_raddr),
    .rdata (alpha_rdata)
  );

  vig_ram #(
    .WIDTH (SW),
    .DEPTH (vig_pkg::KEY_DEPTH),
    .AW    (KAW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (KAW'(in_slot)),
    .wdata (in_symbol),
    .raddr (kp_cur),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      alphabet_length <= '0;
      key_length      <= vig_pkg::CFG_W'(1);
      decrypt_mode    <= 1'b0;
      key_position    <= '0;
      kp_cur          <= '0;
      scan_cnt        <= '0;
      rd_vld          <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vig_pkg::CFG_ALPHA_LEN: alphabet_length <= cfg_data;
          vig_pkg::CFG_KEY_LEN:   key_length      <= cfg_data;
          vig_pkg::CFG_DECRYPT:   decrypt_mode    <= cfg_data[0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != ST_OUT_WR) begin
        m_tvalid <= 1'b0;
      end

      if (state == ST_SCAN_KEY || state == ST_SCAN_TXT) begin
        if (hit || miss) begin
          scan_cnt <= '0;
          rd_vld   <= 1'b0;
        end else begin
          rd_vld <= issue;
          rd_idx <= issue_addr;
          if (issue) begin
            scan_cnt <= scan_cnt + ALW'(1);
          end
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && in_func == vig_pkg::FUNC_TEXT) begin
            sym          <= in_symbol;
            kp_cur       <= kp_start;
            key_position <= kp_after;
            scan_cnt     <= '0;
            rd_vld       <= 1'b0;
            state        <= ST_KEY_RD;
          end
        end
        ST_KEY_RD: begin
          state <= ST_SCAN_KEY;
        end
        ST_SCAN_KEY: begin
          if (hit) begin
            shift <= rd_idx;
            state <= ST_SCAN_TXT;
          end else if (miss) begin
            shift <= '0;
            state <= ST_SCAN_TXT;
          end
        end
        ST_SCAN_TXT: begin
          if (hit) begin
            found   <= 1'b1;
            out_idx <= idx_next;
            state   <= ST_OUT_RD;
          end else if (miss) begin
            found <= 1'b0;
            state <= ST_OUT_WR;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_WR;
        end
        ST_OUT_WR: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= found;
            m_tdata  <= vig_pkg::M_TDATA_W'(found ? alpha_rdata : sym);
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_KEY || state == ST_SCAN_TXT) |-> (scan_cnt <= alen))
    else $error("scan counter beyond alphabet length");

  a_kp_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KEY_RD) |-> (32'(kp_cur) < 32'(klen)))
    else $error("key position beyond key length");

  a_kp_next: assert property (@(posedge clk) disable iff (rst)
    (accept && in_func == vig_pkg::FUNC_TEXT) |=> (32'(key_position) < 32'(klen)))
    else $error("next key position beyond key length");

  a_out_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_RD) |-> (IW'(out_idx) < IW'(alen)))
    else $error("shifted index beyond alphabet length");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_WR && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not delivered to output register");
`endif

endmodule

[dv/alphabet_vigenere_cipher_tb.sv]
// ----------------------------------------------------------------------------
// alphabet_vigenere_cipher_tb
// Self-checking bench for the alphabet Vigenere cipher. Load, text and
// reserved beats go in on the input stream. A behavioral copy of the cipher
// is kept in step with every accepted beat and predicts each result. The
// output stream is checked against those predictions in order. Both sides
// idle at random, and several register settings are covered, extremes
// included.
// ----------------------------------------------------------------------------
module alphabet_vigenere_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W      = vig_pkg::FUNC_W;
  localparam int SYM_W       = vig_pkg::SYM_W;
  localparam int SLOT_W      = vig_pkg::SLOT_W;
  localparam int CFG_W       = vig_pkg::CFG_W;
  localparam int CFG_IDX_W   = vig_pkg::CFG_IDX_W;
  localparam int S_TDATA_W   = vig_pkg::S_TDATA_W;
  localparam int M_TDATA_W   = vig_pkg::M_TDATA_W;
  localparam int ALPHA_DEPTH = vig_pkg::ALPHA_DEPTH;
  localparam int KEY_DEPTH   = vig_pkg::KEY_DEPTH;

  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
  localparam logic [SYM_W-1:0] SYM_MAX = 21'h10FFFF;
  localparam int SETTLE_CYCLES = 2 * ALPHA_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEATS = 1600;
  localparam int PHASES = 10;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             in_alphabet;
  } cipher_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [FUNC_W-1:0]    s_tuser;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 m_tuser;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  logic [SYM_W-1:0] alpha_mem [ALPHA_DEPTH];
  logic [SYM_W-1:0] key_mem [KEY_DEPTH];
  int unsigned      key_pos;
  int unsigned      alpha_len;
  int unsigned      key_len;
  bit               decrypt;
  cipher_result_t   cipher_q[$];
  int unsigned      errors = 0;
  bit               calm = 1'b0;
  int unsigned      stall_count = 0;

  alphabet_vigenere_cipher i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic logic [SYM_W-1:0] random_symbol();
    return SYM_W'($urandom_range(0, SYM_MAX));
  endfunction

  function automatic int unsigned alpha_span();
    return (alpha_len > ALPHA_DEPTH) ? ALPHA_DEPTH : alpha_len;
  endfunction

  function automatic int unsigned alpha_index(logic [SYM_W-1:0] sym, int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if (alpha_mem[i] == sym) return i;
    end
    return len;
  endfunction

  function automatic void predict_cipher(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] sym,
                                         logic [SLOT_W-1:0] slot, logic first);
    int unsigned alen;
    int unsigned klen;
    int unsigned kp;
    int unsigned ti;
    int unsigned shift;
    int unsigned idx;
    alen = alpha_span();
    klen = (key_len == 0) ? 1 : ((key_len > KEY_DEPTH) ? KEY_DEPTH : key_len);
    case (func)
      vig_pkg::FUNC_LOAD_ALPHA: alpha_mem[slot] = sym;
      vig_pkg::FUNC_LOAD_KEY: key_mem[slot] = sym;
      vig_pkg::FUNC_TEXT: begin
        kp = first ? 0 : key_pos;
        if (kp >= klen) kp = 0;
        ti = alpha_index(sym, alen);
        shift = alpha_index(key_mem[kp], alen);
        if (shift >= alen) shift = 0;
        if (ti < alen) begin
          idx = decrypt ? ti + alen - shift : ti + shift;
          if (idx >= alen) idx -= alen;
          cipher_q.push_back(cipher_result_t'{alpha_mem[idx], 1'b1});
        end else begin
          cipher_q.push_back(cipher_result_t'{sym, 1'b0});
        end
        key_pos = (kp + 1 >= klen) ? 0 : kp + 1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(logic [FUNC_W-1:0] func, logic [SYM_W-1:0] sym,
                           logic [SLOT_W-1:0] slot, logic first);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {{(S_TDATA_W - SYM_W - SLOT_W - 1){1'b0}}, first, slot, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_cipher(func, sym, slot, first);
  endtask

  task automatic wait_results(int unsigned extra);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      vig_pkg::CFG_ALPHA_LEN: alpha_len = value & 32'h7F;
      vig_pkg::CFG_KEY_LEN: key_len = value & 32'h7F;
      vig_pkg::CFG_DECRYPT: decrypt = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned alen, int unsigned klen, int unsigned dec);
    wait_results(SETTLE_CYCLES);
    write_reg(vig_pkg::CFG_ALPHA_LEN, alen);
    write_reg(vig_pkg::CFG_KEY_LEN, klen);
    write_reg(vig_pkg::CFG_DECRYPT, dec);
  endtask

  task automatic send_random_beat(output bit counted);
    int unsigned pick;
    int unsigned span;
    logic [SYM_W-1:0] sym;
    logic [SLOT_W-1:0] slot;
    pick = $urandom_range(0, 99);
    span = alpha_span();
    slot = SLOT_W'($urandom_range(0, ALPHA_DEPTH - 1));
    counted = 1'b1;
    if (pick < 8) begin
      sym = ($urandom_range(0, 3) == 0) ? alpha_mem[$urandom_range(0, ALPHA_DEPTH - 1)]
                                        : random_symbol();
      send_beat(vig_pkg::FUNC_LOAD_ALPHA, sym, slot, 1'($urandom_range(0, 1)));
    end else if (pick < 14) begin
      sym = ($urandom_range(0, 4) == 0) ? random_symbol()
                                        : alpha_mem[$urandom_range(0, ALPHA_DEPTH - 1)];
      send_beat(vig_pkg::FUNC_LOAD_KEY, sym, slot, 1'($urandom_range(0, 1)));
    end else if (pick < 16) begin
      counted = 1'b0;
      send_beat(FUNC_RESERVED, random_symbol(), slot, 1'($urandom_range(0, 1)));
    end else begin
      sym = (span != 0 && $urandom_range(0, 9) < 7) ? alpha_mem[$urandom_range(0, span - 1)]
                                                    : random_symbol();
      send_beat(vig_pkg::FUNC_TEXT, sym, slot, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic load_tables();
    for (int i = 0; i < ALPHA_DEPTH; i++) begin
      send_beat(vig_pkg::FUNC_LOAD_ALPHA,
                (i == 0) ? '0 : ((i == ALPHA_DEPTH - 1) ? SYM_MAX : random_symbol()),
                SLOT_W'(i), 1'(i % 2));
    end
    send_beat(vig_pkg::FUNC_LOAD_ALPHA, alpha_mem[7], SLOT_W'(40), 1'b0);
    for (int i = 0; i < KEY_DEPTH; i++) begin
      send_beat(vig_pkg::FUNC_LOAD_KEY,
                (i == 2) ? random_symbol() : alpha_mem[$urandom_range(0, ALPHA_DEPTH - 1)],
                SLOT_W'(i), 1'b0);
    end
  endtask

  task automatic test_reset_passthrough();
    send_beat(vig_pkg::FUNC_TEXT, '0, '0, 1'b1);
    send_beat(vig_pkg::FUNC_TEXT, SYM_MAX, '1, 1'b0);
    send_beat(vig_pkg::FUNC_TEXT, random_symbol(), SLOT_W'($urandom_range(0, 63)), 1'b0);
  endtask

  task automatic test_field_extremes();
    set_config(ALPHA_DEPTH, 3, 0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[0], '0, 1'b1);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[ALPHA_DEPTH - 1], '1, 1'b0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[40], '0, 1'b0);
    send_beat(FUNC_RESERVED, SYM_MAX, '1, 1'b1);
    send_beat(vig_pkg::FUNC_LOAD_KEY, alpha_mem[1], '1, 1'b1);
    send_beat(vig_pkg::FUNC_TEXT, random_symbol(), 6'h15, 1'b0);
    set_config(ALPHA_DEPTH, 3, 1);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[0], '0, 1'b1);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[ALPHA_DEPTH - 1], '0, 1'b0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[10], '0, 1'b0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[11], '0, 1'b0);
  endtask

  task automatic test_lengths();
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[12], '0, 1'b0);
    set_config(ALPHA_DEPTH, 1, 1);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[13], '0, 1'b0);
    set_config(ALPHA_DEPTH, 0, 0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[14], '0, 1'b0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[15], '0, 1'b0);
    set_config(127, 127, 0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[ALPHA_DEPTH - 1], '0, 1'b1);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[20], '0, 1'b0);
    set_config(1, KEY_DEPTH, 1);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[0], '0, 1'b0);
    send_beat(vig_pkg::FUNC_TEXT, alpha_mem[1], '0, 1'b0);
  endtask

  task automatic test_pause_for_results();
    bit counted;
    set_config(ALPHA_DEPTH, 7, 0);
    repeat (40) send_random_beat(counted);
    wait_results(0);
    repeat (40) send_random_beat(counted);
  endtask

  task automatic test_random_traffic();
    int unsigned alens [PHASES] = '{64, 1, 2, 127, 0, 37, 64, 65, 10, 64};
    int unsigned klens [PHASES] = '{1, 64, 0, 127, 5, 3, 17, 1, 64, 2};
    int unsigned sent;
    bit counted;
    for (int unsigned p = 0; p < PHASES; p++) begin
      set_config(alens[p], klens[p], p % 2);
      calm = (p == 6);
      sent = 0;
      while (sent < RANDOM_BEATS / PHASES) begin
        send_random_beat(counted);
        if (counted) sent++;
      end
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 25);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin : check_result
      cipher_result_t want;
      if (cipher_q.size() == 0) begin
        flag_error($sformatf("result with nothing expected: symbol %h in_alphabet %b",
                             m_tdata[SYM_W-1:0], m_tuser));
      end else begin
        want = cipher_q.pop_front();
        if (m_tdata[SYM_W-1:0] !== want.out_symbol || m_tuser !== want.in_alphabet) begin
          flag_error($sformatf("symbol exp %h got %h, in_alphabet exp %b got %b",
                               want.out_symbol, m_tdata[SYM_W-1:0],
                               want.in_alphabet, m_tuser));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    key_pos = 0;
    alpha_len = 0;
    key_len = 1;
    decrypt = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    load_tables();
    test_reset_passthrough();
    test_field_extremes();
    test_lengths();
    test_pause_for_results();
    test_random_traffic();
    wait_results(SETTLE_CYCLES);
    if (cipher_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", cipher_q.size()));
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
